// ===== src/chsi_pkg.sv =====
package chsi_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int VALUE_BITS    = 16;

    localparam int ADC_W  = 5;
    localparam int DC_W   = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int PIPE_STAGES = 7;
    localparam int CNT_W       = $clog2(PIPE_STAGES + 1);

    localparam logic [ADC_W-1:0] ADC_MIN = ADC_W'(8);
    localparam logic [ADC_W-1:0] ADC_MAX = ADC_W'(SAMPLE_BITS);
    localparam int DCX_W = (SAMPLE_BITS > DC_W) ? SAMPLE_BITS : DC_W;

    localparam logic [ADC_W-1:0] ADC_WIDTH_RESET = ADC_W'(14);
    localparam logic [DC_W-1:0]  DC_LEVEL_RESET  = DC_W'(32000);

    localparam int CA_W   = SAMPLE_BITS + 3;
    localparam int CB_W   = SAMPLE_BITS + 4;
    localparam int CC_W   = SAMPLE_BITS + 1;
    localparam int PA_W   = FRACTION_BITS + 1 + CA_W;
    localparam int S2_W   = SAMPLE_BITS + FRACTION_BITS + 5;
    localparam int H2_W   = S2_W - FRACTION_BITS;
    localparam int FH2_W  = FRACTION_BITS + 1 + H2_W;
    localparam int T_W    = SAMPLE_BITS + FRACTION_BITS + 6;
    localparam int H1_W   = T_W - FRACTION_BITS;
    localparam int FH1_W  = FRACTION_BITS + 1 + H1_W;
    localparam int Q_W    = 2 * FRACTION_BITS + 1;
    localparam int TOP_W  = SAMPLE_BITS + FRACTION_BITS + 7;
    localparam int IP_W   = TOP_W - FRACTION_BITS - 1;
    localparam int BASE_W = IP_W + 2;

    localparam logic signed [BASE_W-1:0] VALUE_MAX = BASE_W'((2 ** (VALUE_BITS - 1)) - 1);
    localparam logic signed [BASE_W-1:0] VALUE_MIN = -BASE_W'(2 ** (VALUE_BITS - 1));

    typedef enum logic [1:0] {
        REG_RENORMALIZE = 2'd0,
        REG_ADC_WIDTH   = 2'd1,
        REG_DC_LEVEL    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   sample_newest;
        logic [SAMPLE_BITS-1:0]   sample_back1;
        logic [SAMPLE_BITS-1:0]   sample_back2;
        logic [SAMPLE_BITS-1:0]   sample_back3;
        logic [FRACTION_BITS-1:0] fraction;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
    } result_t;

endpackage

// ===== src/chsi_if.sv =====
interface chsi_item_if
    import chsi_pkg::*;
;
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface chsi_result_if
    import chsi_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/cubic_hermite_sample_interpolator.sv =====
// channel   role    beat
// item      sink    four samples and a fraction
// result    source  one interpolated int16 value
// apb       slave   renormalize, adc_width, dc_level at 0x0, 0x4, 0x8
//
// seven register stages, one beat per cycle while the result is accepted
// the fraction products of the cubic set the stage count
// rst_n clears the stage valid bits and the configuration registers to their reset values
// a stalled result holds its stage; bubbles ahead of a stall are filled
module cubic_hermite_sample_interpolator
    import chsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    chsi_item_if.sink          item,
    chsi_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int FB = FRACTION_BITS;
    localparam int SB = SAMPLE_BITS;

    // configuration
    logic              renormalize_reg, renormalize_next;
    logic [ADC_W-1:0]  adc_width_reg, adc_width_next;
    logic [DC_W-1:0]   dc_level_reg, dc_level_next;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        renormalize_next = renormalize_reg;
        adc_width_next   = adc_width_reg;
        dc_level_next    = dc_level_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                REG_RENORMALIZE: renormalize_next = pwdata[0];
                REG_ADC_WIDTH:   adc_width_next   = pwdata[ADC_W-1:0];
                REG_DC_LEVEL:    dc_level_next    = pwdata[DC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RENORMALIZE: prdata = DATA_W'(renormalize_reg);
            REG_ADC_WIDTH:   prdata = DATA_W'(adc_width_reg);
            REG_DC_LEVEL:    prdata = DATA_W'(dc_level_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            renormalize_reg <= 1'b0;
            adc_width_reg   <= ADC_WIDTH_RESET;
            dc_level_reg    <= DC_LEVEL_RESET;
        end
        else
        begin
            renormalize_reg <= renormalize_next;
            adc_width_reg   <= adc_width_next;
            dc_level_reg    <= dc_level_next;
        end
    end

    // stage handshake
    logic [PIPE_STAGES-1:0] vld_reg, vld_next;
    logic [PIPE_STAGES:0]   rdy;

    always_comb
    begin
        rdy[PIPE_STAGES] = result.ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = (i == 0) ? item.valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    assign item.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 0: sample decode
    function automatic logic signed [SB-1:0] decode(
        input logic [SB-1:0]    raw,
        input logic             ren,
        input logic [ADC_W-1:0] sh,
        input logic [SB-1:0]    dc
    );
        logic [SB-1:0] s;
        s = ren ? ((raw >> sh) - dc) : raw;
        return signed'(s);
    endfunction

    logic [ADC_W-1:0] width_clamped;
    logic [ADC_W-1:0] shamt;
    logic [SB-1:0]    dc_shifted;

    assign width_clamped = (adc_width_reg < ADC_MIN) ? ADC_MIN :
                           (adc_width_reg > ADC_MAX) ? ADC_MAX : adc_width_reg;
    assign shamt         = ADC_MAX - width_clamped;
    assign dc_shifted    = SB'(DCX_W'(dc_level_reg) >> shamt);

    logic signed [SB-1:0] s0_x0_reg, s0_x1_reg, s0_x2_reg, s0_x3_reg;
    logic signed [SB-1:0] s0_x0_next, s0_x1_next, s0_x2_next, s0_x3_next;
    logic [FB-1:0]        s0_f_reg, s0_f_next;

    assign s0_x0_next = decode(item.payload.sample_newest, renormalize_reg, shamt, dc_shifted);
    assign s0_x1_next = decode(item.payload.sample_back1, renormalize_reg, shamt, dc_shifted);
    assign s0_x2_next = decode(item.payload.sample_back2, renormalize_reg, shamt, dc_shifted);
    assign s0_x3_next = decode(item.payload.sample_back3, renormalize_reg, shamt, dc_shifted);
    assign s0_f_next  = item.payload.fraction;

    // stage 1: doubled coefficients
    logic signed [CA_W-1:0] e_d21, e_d03;
    logic signed [CB_W-1:0] b_x0, b_x1, b_x2, b_x3;
    logic signed [CA_W-1:0] s1_ca_reg, s1_ca_next;
    logic signed [CB_W-1:0] s1_cb_reg, s1_cb_next;
    logic signed [CC_W-1:0] s1_cc_reg, s1_cc_next;
    logic signed [SB-1:0]   s1_x2_reg;
    logic [FB-1:0]          s1_f_reg;

    assign e_d21      = CA_W'(s0_x2_reg) - CA_W'(s0_x1_reg);
    assign e_d03      = CA_W'(s0_x0_reg) - CA_W'(s0_x3_reg);
    assign s1_ca_next = (e_d21 <<< 1) + e_d21 + e_d03;
    assign b_x0       = CB_W'(s0_x0_reg);
    assign b_x1       = CB_W'(s0_x1_reg);
    assign b_x2       = CB_W'(s0_x2_reg);
    assign b_x3       = CB_W'(s0_x3_reg);
    assign s1_cb_next = (b_x1 <<< 2) + (b_x3 <<< 1) - (b_x2 <<< 2) - b_x2 - b_x0;
    assign s1_cc_next = CC_W'(s0_x1_reg) - CC_W'(s0_x3_reg);

    // stage 2: cb * 2^fb + f * ca
    logic signed [FB:0]     s1_fs;
    logic signed [PA_W-1:0] prod_a;
    logic signed [S2_W-1:0] s2_sum_reg, s2_sum_next;
    logic signed [CC_W-1:0] s2_cc_reg;
    logic signed [SB-1:0]   s2_x2_reg;
    logic [FB-1:0]          s2_f_reg;

    assign s1_fs       = signed'({1'b0, s1_f_reg});
    assign prod_a      = s1_fs * s1_ca_reg;
    assign s2_sum_next = (S2_W'(s1_cb_reg) <<< FB) + S2_W'(prod_a);

    // stage 3: cc * 2^fb + f * h2 + carry of f * l2
    logic signed [FB:0]      s2_fs;
    logic signed [H2_W-1:0]  h2;
    logic [FB-1:0]           l2;
    logic [2*FB-1:0]         prod_l2;
    logic signed [FH2_W-1:0] prod_h2;
    logic signed [T_W-1:0]   s3_t_reg, s3_t_next;
    logic [FB-1:0]           s3_u_reg, s3_u_next;
    logic signed [SB-1:0]    s3_x2_reg;
    logic [FB-1:0]           s3_f_reg;

    assign s2_fs     = signed'({1'b0, s2_f_reg});
    assign h2        = s2_sum_reg[S2_W-1:FB];
    assign l2        = s2_sum_reg[FB-1:0];
    assign prod_l2   = s2_f_reg * l2;
    assign prod_h2   = s2_fs * h2;
    assign s3_t_next = (T_W'(s2_cc_reg) <<< FB) + T_W'(prod_h2)
                     + T_W'(signed'({1'b0, prod_l2[2*FB-1:FB]}));
    assign s3_u_next = prod_l2[FB-1:0];

    // stage 4: middle and low limbs, f * h1
    logic signed [FB:0]      s3_fs;
    logic signed [H1_W-1:0]  h1;
    logic [FB-1:0]           m1;
    logic [2*FB-1:0]         prod_u;
    logic [2*FB-1:0]         prod_m1;
    logic [Q_W-1:0]          s4_q_reg, s4_q_next;
    logic signed [FH1_W-1:0] s4_fh1_reg, s4_fh1_next;
    logic                    s4_low_zero_reg, s4_low_zero_next;
    logic signed [SB-1:0]    s4_x2_reg;

    assign s3_fs            = signed'({1'b0, s3_f_reg});
    assign h1               = s3_t_reg[T_W-1:FB];
    assign m1               = s3_t_reg[FB-1:0];
    assign prod_u           = s3_f_reg * s3_u_reg;
    assign prod_m1          = s3_f_reg * m1;
    assign s4_q_next        = Q_W'(prod_m1) + Q_W'(prod_u[2*FB-1:FB]);
    assign s4_low_zero_next = (prod_u[FB-1:0] == '0);
    assign s4_fh1_next      = s3_fs * h1;

    // stage 5: top limb
    logic signed [TOP_W-1:0] s5_top_reg, s5_top_next;
    logic                    s5_frac_zero_reg, s5_frac_zero_next;
    logic signed [SB-1:0]    s5_x2_reg;

    assign s5_top_next       = TOP_W'(s4_fh1_reg) + TOP_W'(signed'({1'b0, s4_q_reg[Q_W-1:FB]}));
    assign s5_frac_zero_next = s4_low_zero_reg && (s4_q_reg[FB-1:0] == '0);

    // stage 6: round half to even, saturate
    logic signed [IP_W-1:0]   ip;
    logic [FB:0]              rtop;
    logic                     round_up;
    logic signed [BASE_W-1:0] base;
    logic signed [BASE_W-1:0] base_rnd;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;

    assign ip       = s5_top_reg[TOP_W-1:FB+1];
    assign rtop     = s5_top_reg[FB:0];
    assign base     = BASE_W'(s5_x2_reg) + BASE_W'(ip);
    assign round_up = (rtop == {1'b1, {FB{1'b0}}} && s5_frac_zero_reg) ? base[0] : rtop[FB];
    assign base_rnd = base + BASE_W'(round_up);

    always_comb
    begin
        if (base_rnd > VALUE_MAX)
        begin
            value_next = VALUE_MAX[VALUE_BITS-1:0];
        end
        else if (base_rnd < VALUE_MIN)
        begin
            value_next = VALUE_MIN[VALUE_BITS-1:0];
        end
        else
        begin
            value_next = base_rnd[VALUE_BITS-1:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s0_x0_reg <= s0_x0_next;
            s0_x1_reg <= s0_x1_next;
            s0_x2_reg <= s0_x2_next;
            s0_x3_reg <= s0_x3_next;
            s0_f_reg  <= s0_f_next;
        end
        if (rdy[1])
        begin
            s1_ca_reg <= s1_ca_next;
            s1_cb_reg <= s1_cb_next;
            s1_cc_reg <= s1_cc_next;
            s1_x2_reg <= s0_x2_reg;
            s1_f_reg  <= s0_f_reg;
        end
        if (rdy[2])
        begin
            s2_sum_reg <= s2_sum_next;
            s2_cc_reg  <= s1_cc_reg;
            s2_x2_reg  <= s1_x2_reg;
            s2_f_reg   <= s1_f_reg;
        end
        if (rdy[3])
        begin
            s3_t_reg  <= s3_t_next;
            s3_u_reg  <= s3_u_next;
            s3_x2_reg <= s2_x2_reg;
            s3_f_reg  <= s2_f_reg;
        end
        if (rdy[4])
        begin
            s4_q_reg        <= s4_q_next;
            s4_fh1_reg      <= s4_fh1_next;
            s4_low_zero_reg <= s4_low_zero_next;
            s4_x2_reg       <= s3_x2_reg;
        end
        if (rdy[5])
        begin
            s5_top_reg       <= s5_top_next;
            s5_frac_zero_reg <= s5_frac_zero_next;
            s5_x2_reg        <= s4_x2_reg;
        end
        if (rdy[6])
        begin
            value_reg <= value_next;
        end
    end

    assign result.valid         = vld_reg[PIPE_STAGES-1];
    assign result.payload.value = value_reg;

endmodule

// ===== src/chsi_checker.sv =====
module chsi_checker
    import chsi_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic signed [VALUE_BITS-1:0] result_value
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PIPE_STAGES);

    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             item_beat;
    logic             result_beat;

    assign item_beat     = item_valid && item_ready;
    assign result_beat   = result_valid && result_ready;
    assign inflight_next = inflight_reg + CNT_W'(item_beat) - CNT_W'(result_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a stalled result keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_value))
        else $error("result beat dropped or changed under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_MAX)
        else $error("more beats in flight than pipeline stages");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != '0)
        else $error("result beat without an accepted item");

    // a draining output never back-pressures the input
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("input stalled while output drains");

endmodule

bind cubic_hermite_sample_interpolator chsi_checker u_chsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.payload.value)
);

// ===== tb/cubic_hermite_sample_interpolator_test.sv =====
`timescale 1ns / 1ps

module cubic_hermite_sample_interpolator_test;
    import chsi_pkg::*;

    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(12);
    localparam int ITEMS_PER_PHASE = 80;
    localparam int PHASES = 12;
    localparam int LONG_HOLD = 60;

    class value_scoreboard;
        logic              renorm;
        logic [ADC_W-1:0]  adc_w;
        logic [DC_W-1:0]   dc_lvl;
        result_t           expected_values[$];
        int                errors;
        int                checked;

        function new();
            renorm = 1'b0;
            adc_w = ADC_WIDTH_RESET;
            dc_lvl = DC_LEVEL_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            if (addr[1:0] == 2'b00)
            begin
                case (reg_idx_t'(addr[ADDR_W-1:2]))
                    REG_RENORMALIZE: renorm = data[0];
                    REG_ADC_WIDTH:   adc_w = data[ADC_W-1:0];
                    REG_DC_LEVEL:    dc_lvl = data[DC_W-1:0];
                    default: ;
                endcase
            end
        endfunction

        // raw code to two's complement sample, with optional shift and dc removal
        function logic signed [SAMPLE_BITS-1:0] decode_code(logic [SAMPLE_BITS-1:0] raw);
            int                     w;
            int                     sh;
            logic [SAMPLE_BITS-1:0] s;
            logic [SAMPLE_BITS-1:0] d;
            s = raw;
            if (renorm)
            begin
                w = adc_w;
                if (w < 8)
                    w = 8;
                if (w > SAMPLE_BITS)
                    w = SAMPLE_BITS;
                sh = SAMPLE_BITS - w;
                s = raw >> sh;
                d = SAMPLE_BITS'(dc_lvl >> sh);
                s = s - d;
            end
            return s;
        endfunction

        function result_t predict_value(item_t it);
            logic signed [79:0] x0, x1, x2, x3, f;
            logic signed [79:0] ca, cb, cc, acc, ip, rem, half, base;
            result_t            r;
            x0 = decode_code(it.sample_newest);
            x1 = decode_code(it.sample_back1);
            x2 = decode_code(it.sample_back2);
            x3 = decode_code(it.sample_back3);
            f = {64'd0, it.fraction};
            // doubled coefficients, result is x2 + acc / 2^(3*16+1)
            ca = 3 * (x2 - x1) + (x0 - x3);
            cb = 4 * x1 + 2 * x3 - 5 * x2 - x0;
            cc = x1 - x3;
            acc = ((ca * f + (cb <<< FRACTION_BITS)) * f + (cc <<< (2 * FRACTION_BITS))) * f;
            ip = acc >>> (3 * FRACTION_BITS + 1);
            rem = acc - (ip <<< (3 * FRACTION_BITS + 1));
            half = 80'sd1 <<< (3 * FRACTION_BITS);
            base = x2 + ip;
            if (rem > half || (rem == half && base[0]))
                base = base + 1;
            if (base > 32767)
                base = 32767;
            else if (base < -32768)
                base = -32768;
            r.value = base[VALUE_BITS-1:0];
            return r;
        endfunction

        function void note_item(item_t it);
            expected_values.push_back(predict_value(it));
        endfunction

        function void check_value(result_t got);
            result_t want;
            if (expected_values.size() == 0)
            begin
                $error("unexpected result beat, value %0d", got.value);
                errors++;
            end
            else
            begin
                want = expected_values.pop_front();
                checked++;
                if (got.value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, got.value);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic             pready;

    chsi_item_if   item_ch();
    chsi_result_if result_ch();

    value_scoreboard sb = new();

    int max_item_gap;
    int max_result_gap;
    int stall_request;
    int settings_used;
    int items_sent;

    logic [SAMPLE_BITS-1:0] corner_codes [5];

    cubic_hermite_sample_interpolator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("cubic_hermite_sample_interpolator test failed");
        $finish;
    end

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.expected_values.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        wait_drained();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(addr, data);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    // unused upper bits of pwdata carry random junk
    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] field);
        logic [DATA_W-1:0] data;
        data = $urandom();
        case (idx)
            REG_RENORMALIZE: data[0] = field[0];
            REG_ADC_WIDTH:   data[ADC_W-1:0] = field[ADC_W-1:0];
            REG_DC_LEVEL:    data[DC_W-1:0] = field[DC_W-1:0];
            default: ;
        endcase
        apb_write({idx, 2'b00}, data);
    endtask

    task automatic send_item(item_t it);
        int gap;
        gap = $urandom_range(0, max_item_gap);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_samples(logic [15:0] n, logic [15:0] b1, logic [15:0] b2,
                                logic [15:0] b3, logic [15:0] f);
        item_t it;
        it.sample_newest = n;
        it.sample_back1 = b1;
        it.sample_back2 = b2;
        it.sample_back3 = b3;
        it.fraction = f;
        send_item(it);
    endtask

    function automatic item_t random_item();
        item_t                  it;
        int                     kind;
        logic [SAMPLE_BITS-1:0] b;
        logic [SAMPLE_BITS-1:0] step;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            // slowly moving signal, the common case
            b = SAMPLE_BITS'($urandom());
            step = SAMPLE_BITS'($urandom_range(0, 4096)) - SAMPLE_BITS'(2048);
            it.sample_back3 = b;
            it.sample_back2 = b + step + SAMPLE_BITS'($urandom_range(0, 63));
            it.sample_back1 = b + SAMPLE_BITS'(2) * step
                            + SAMPLE_BITS'($urandom_range(0, 63));
            it.sample_newest = b + SAMPLE_BITS'(3) * step
                             + SAMPLE_BITS'($urandom_range(0, 63));
        end
        else if (kind < 8)
        begin
            it.sample_newest = SAMPLE_BITS'($urandom());
            it.sample_back1 = SAMPLE_BITS'($urandom());
            it.sample_back2 = SAMPLE_BITS'($urandom());
            it.sample_back3 = SAMPLE_BITS'($urandom());
        end
        else
        begin
            it.sample_newest = corner_codes[$urandom_range(0, 4)];
            it.sample_back1 = corner_codes[$urandom_range(0, 4)];
            it.sample_back2 = corner_codes[$urandom_range(0, 4)];
            it.sample_back3 = corner_codes[$urandom_range(0, 4)];
        end
        case ($urandom_range(0, 7))
            0: it.fraction = '0;
            1: it.fraction = '1;
            2: it.fraction = FRACTION_BITS'(1) << (FRACTION_BITS - 1);
            3: it.fraction = FRACTION_BITS'(1);
            default: it.fraction = FRACTION_BITS'($urandom());
        endcase
        return it;
    endfunction

    // result side
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = (stall_request > 0) ? stall_request : $urandom_range(0, max_result_gap);
            stall_request = 0;
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            sb.check_value(result_ch.payload);
        end
    end

    initial
    begin
        int p;
        int i;
        corner_codes[0] = 16'h0000;
        corner_codes[1] = 16'h0001;
        corner_codes[2] = 16'h7FFF;
        corner_codes[3] = 16'h8000;
        corner_codes[4] = 16'hFFFF;
        max_item_gap = 3;
        max_result_gap = 3;
        stall_request = 0;
        settings_used = 0;
        items_sent = 0;
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.payload <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two's complement samples with the reset settings
        send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_samples(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0000);
        send_samples(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'hFFFF);
        send_samples(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h8000);
        send_samples(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0001);
        // overshoot past both rails
        send_samples(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_samples(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        // exact halves on a straight line, rounding to even
        send_samples(16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h8000);
        send_samples(16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h8000);
        send_samples(16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF, 16'h8000);
        send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // raw codes
        write_reg(REG_RENORMALIZE, 1);
        send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_samples(16'd32000, 16'd32000, 16'd32000, 16'd32000, 16'h1234);
        write_reg(REG_ADC_WIDTH, 8);
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);
        write_reg(REG_ADC_WIDTH, 16);
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);
        // widths outside the ADC range clamp to the nearest limit
        write_reg(REG_ADC_WIDTH, 3);
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);
        write_reg(REG_ADC_WIDTH, 31);
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);
        write_reg(REG_DC_LEVEL, 0);
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);
        write_reg(REG_DC_LEVEL, 16'hFFFF);
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);
        // a write to an unmapped address must change nothing
        apb_write(UNUSED_ADDR, $urandom());
        send_samples(16'hFFFF, 16'h0100, 16'h8000, 16'h0000, 16'hC000);

        for (p = 0; p < PHASES; p++)
        begin
            write_reg(REG_RENORMALIZE, (p % 3 == 0) ? 0 : $urandom_range(0, 1));
            case (p % 4)
                0: write_reg(REG_ADC_WIDTH, 8);
                1: write_reg(REG_ADC_WIDTH, 16);
                2: write_reg(REG_ADC_WIDTH, $urandom_range(0, 31));
                default: write_reg(REG_ADC_WIDTH, $urandom_range(8, 16));
            endcase
            case (p % 5)
                0: write_reg(REG_DC_LEVEL, 0);
                1: write_reg(REG_DC_LEVEL, 16'hFFFF);
                default: write_reg(REG_DC_LEVEL, $urandom_range(0, 65535));
            endcase
            if (p % 3 == 0)
            begin
                max_item_gap = 0;
                max_result_gap = 0;
            end
            else
            begin
                max_item_gap = 8;
                max_result_gap = 8;
            end
            // fill the pipe against a stalled output
            if (p == 4)
            begin
                max_item_gap = 0;
                stall_request = LONG_HOLD;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(random_item());
        end

        wait_drained();
        repeat (PIPE_STAGES * 3) @(posedge clk);
        $display("sent %0d item beats across %0d register writes, checked %0d result beats",
                 items_sent, settings_used, sb.checked);
        if (sb.errors == 0 && sb.expected_values.size() == 0)
            $display("cubic_hermite_sample_interpolator test passed");
        else
            $display("cubic_hermite_sample_interpolator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/chsi_pkg.sv
src/chsi_if.sv
src/cubic_hermite_sample_interpolator.sv
src/chsi_checker.sv
tb/cubic_hermite_sample_interpolator_test.sv
